/* rtl/tree_path_min_query_top_assert.svh */
// assertion macros for the tree path minimum block
// no dependencies; taken in by the modules that assert
`ifndef TREE_PATH_MIN_QUERY_TOP_ASSERT_SVH
`define TREE_PATH_MIN_QUERY_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TPMQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TPMQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TPMQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define TPMQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/tpmq_pkg.sv */
// shared types and codes for the tree path minimum block
// no dependencies
package tpmq_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_BUILT = 2'd1,
    ST_RANGE     = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE, S_B0_RD, S_B0_WR, S_BK_RD, S_BK_MID, S_BK_WR,
    S_BD_INIT, S_BD_RD, S_BD_CAP, S_BD_WR,
    S_Q_LA, S_Q_LB, S_Q_LVL, S_Q_UP, S_Q_UP_CAP, S_Q_EQ, S_Q_EQ_CAP,
    S_Q_DN_RA, S_Q_DN_RB, S_Q_DN_CAP, S_Q_FA, S_Q_FB, S_Q_FP, S_Q_FIN,
    S_RES
  } state_e;

  typedef struct packed {
    logic    valid;
    status_e status;
  } res_t;

endpackage

/* rtl/tpmq_ram.sv */
// generic simple dual port ram, one write and one registered read
// no dependencies
module tpmq_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [DATA_W-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [DATA_W-1:0]                        rdata_o
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] mem [2**AW];
  logic [DATA_W-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* rtl/tpmq_ctrl.sv */
// sequencer for load, level-wise table build and path minimum query
// depends on tpmq_pkg, tpmq_ram and the assertion macro header
`include "tree_path_min_query_top_assert.svh"
module tpmq_ctrl import tpmq_pkg::*; #(
  parameter int MAX_NODES  = 1024,
  parameter int LEVELS     = 10,
  parameter int VALUE_BITS = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  op_e                                    op_i,
  input  logic [$clog2(MAX_NODES)-1:0]           node_id_i,
  input  logic [$clog2(MAX_NODES)-1:0]           parent_i,
  input  logic signed [VALUE_BITS-1:0]           value_i,
  input  logic [$clog2(MAX_NODES)-1:0]           node_a_i,
  input  logic [$clog2(MAX_NODES)-1:0]           node_b_i,
  input  logic [$clog2(MAX_NODES+1)-1:0]         count_i,
  input  logic                                   cfg_wr_i,
  output res_t                                   res_o,
  output logic signed [VALUE_BITS-1:0]           res_min_o,
  input  logic                                   res_ready_i
);
  localparam int NB = $clog2(MAX_NODES);
  localparam int CB = $clog2(MAX_NODES + 1);
  localparam int KB = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int DB = LEVELS;
  localparam int AB = KB + NB;
  localparam int VB = VALUE_BITS;
  localparam logic [DB:0] DMAX = (DB+1)'((1 << LEVELS) - 1);
  localparam logic [KB-1:0] KTOP = KB'(LEVELS - 1);
  localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};

  function automatic logic signed [VB-1:0] smin(input logic signed [VB-1:0] x,
                                                  input logic signed [VB-1:0] y);
    return (x < y) ? x : y;
  endfunction

  state_e state_q, state_d;
  logic [CB-1:0] v_q, v_d;
  logic [KB-1:0] k_q, k_d;
  logic [NB-1:0] a_q, a_d, b_q, b_d, x_q, x_d;
  logic [DB:0] d_q, d_d, dfin;
  logic [DB-1:0] la_q, la_d, diff_q, diff_d;
  logic signed [VB-1:0] acc_q, acc_d, m1_q, m1_d;
  logic built_q, built_d;
  status_e st_q, st_d;

  // memory ports
  logic nd_we, jw_we, lv_we;
  logic [NB-1:0] nd_waddr, nd_raddr, lv_waddr, lv_raddr;
  logic [AB-1:0] jw_addr, jr_addr;
  logic [NB+VB-1:0] nd_wdata, nd_rdata, jw_data, jr_rdata;
  logic [DB-1:0] lv_wdata, lv_rdata;
  logic [NB-1:0] nd_par, j_anc, p_fix;
  logic signed [VB-1:0] nd_val, j_mn;
  logic [CB-1:0] last_v;

  assign {nd_par, nd_val} = nd_rdata;
  assign {j_anc, j_mn}    = jr_rdata;
  assign last_v = count_i - CB'(1);

  // node value and loaded parent
  tpmq_ram #(.DATA_W(NB + VB), .DEPTH(2**NB)) u_node_ram (
    .clk_i, .we_i(nd_we), .waddr_i(nd_waddr), .wdata_i(nd_wdata),
    .raddr_i(nd_raddr), .rdata_o(nd_rdata)
  );

  // ancestor and minimum per level, addressed {level, node}
  tpmq_ram #(.DATA_W(NB + VB), .DEPTH(2**AB)) u_jump_ram (
    .clk_i, .we_i(jw_we), .waddr_i(jw_addr), .wdata_i(jw_data),
    .raddr_i(jr_addr), .rdata_o(jr_rdata)
  );

  // node depth
  tpmq_ram #(.DATA_W(DB), .DEPTH(2**NB)) u_lvl_ram (
    .clk_i, .we_i(lv_we), .waddr_i(lv_waddr), .wdata_i(lv_wdata),
    .raddr_i(lv_raddr), .rdata_o(lv_rdata)
  );

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      built_q <= 1'b0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      built_q <= built_d;
      k_q     <= k_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    v_q <= v_d; a_q <= a_d; b_q <= b_d; x_q <= x_d;
    d_q <= d_d; la_q <= la_d; diff_q <= diff_d;
    acc_q <= acc_d; m1_q <= m1_d; st_q <= st_d;
  end

  // next state, datapath and memory control
  always_comb begin
    state_d = state_q; built_d = built_q;
    v_d = v_q; k_d = k_q; a_d = a_q; b_d = b_q; x_d = x_q; d_d = d_q;
    la_d = la_q; diff_d = diff_q; acc_d = acc_q; m1_d = m1_q; st_d = st_q;
    nd_we = 1'b0; nd_waddr = node_id_i; nd_wdata = {parent_i, value_i};
    nd_raddr = a_q;
    jw_we = 1'b0; jw_addr = {k_q, v_q[NB-1:0]}; jw_data = jr_rdata;
    jr_addr = {k_q, a_q};
    lv_we = 1'b0; lv_waddr = v_q[NB-1:0]; lv_wdata = la_q; lv_raddr = a_q;
    in_ready_o = 1'b0;
    res_o.valid = 1'b0; res_o.status = st_q;
    p_fix = nd_par;
    dfin = d_q + (DB+1)'(x_q != '0);
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (op_i)
            OP_LOAD: begin
              built_d = 1'b0;
              nd_we = (CB'(node_id_i) < count_i);
            end
            OP_BUILD: begin
              v_d = '0;
              state_d = S_B0_RD;
            end
            OP_QUERY: begin
              a_d = node_a_i;
              b_d = node_b_i;
              if (!built_q) begin
                st_d = ST_NOT_BUILT; acc_d = '0; state_d = S_RES;
              end else if (CB'(node_a_i) >= count_i || CB'(node_b_i) >= count_i) begin
                st_d = ST_RANGE; acc_d = '0; state_d = S_RES;
              end else begin
                st_d = ST_OK; acc_d = VMAX; state_d = S_Q_LA;
              end
            end
            default: ;
          endcase
        end
      end
      // level zero: parent and own value
      S_B0_RD: begin
        nd_raddr = v_q[NB-1:0];
        state_d = S_B0_WR;
      end
      S_B0_WR: begin
        if (v_q == '0 || CB'(nd_par) >= count_i) p_fix = '0;
        jw_we = 1'b1;
        jw_addr = {KB'(0), v_q[NB-1:0]};
        jw_data = {p_fix, nd_val};
        if (v_q == last_v) begin
          v_d = '0;
          if (LEVELS > 1) begin
            k_d = KB'(1); state_d = S_BK_RD;
          end else begin
            state_d = S_BD_INIT;
          end
        end else begin
          v_d = v_q + CB'(1); state_d = S_B0_RD;
        end
      end
      // higher levels: jump twice through the level below
      S_BK_RD: begin
        jr_addr = {k_q - KB'(1), v_q[NB-1:0]};
        state_d = S_BK_MID;
      end
      S_BK_MID: begin
        m1_d = j_mn;
        jr_addr = {k_q - KB'(1), j_anc};
        state_d = S_BK_WR;
      end
      S_BK_WR: begin
        jw_we = 1'b1;
        jw_data = {j_anc, smin(m1_q, j_mn)};
        if (v_q == last_v) begin
          v_d = '0;
          if (k_q == KTOP) begin
            state_d = S_BD_INIT;
          end else begin
            k_d = k_q + KB'(1); state_d = S_BK_RD;
          end
        end else begin
          v_d = v_q + CB'(1); state_d = S_BK_RD;
        end
      end
      // depth of each node by lifting towards the root
      S_BD_INIT: begin
        x_d = v_q[NB-1:0]; d_d = '0; k_d = KTOP;
        state_d = S_BD_RD;
      end
      S_BD_RD: begin
        jr_addr = {k_q, x_q};
        state_d = S_BD_CAP;
      end
      S_BD_CAP: begin
        if (j_anc != '0) begin
          d_d = d_q + ((DB+1)'(1) << k_q);
          x_d = j_anc;
        end
        if (k_q == '0) begin
          state_d = S_BD_WR;
        end else begin
          k_d = k_q - KB'(1); state_d = S_BD_RD;
        end
      end
      S_BD_WR: begin
        lv_we = 1'b1;
        lv_wdata = (dfin > DMAX) ? DMAX[DB-1:0] : dfin[DB-1:0];
        if (v_q == last_v) begin
          built_d = 1'b1; state_d = S_IDLE;
        end else begin
          v_d = v_q + CB'(1); state_d = S_BD_INIT;
        end
      end
      // query: depths of both ends
      S_Q_LA: begin
        lv_raddr = a_q; state_d = S_Q_LB;
      end
      S_Q_LB: begin
        la_d = lv_rdata; lv_raddr = b_q; state_d = S_Q_LVL;
      end
      S_Q_LVL: begin
        if (la_q < lv_rdata) begin
          a_d = b_q; b_d = a_q; diff_d = lv_rdata - la_q;
        end else begin
          diff_d = la_q - lv_rdata;
        end
        k_d = '0; state_d = S_Q_UP;
      end
      // lift the deeper end by the depth difference
      S_Q_UP: begin
        jr_addr = {k_q, a_q};
        if (diff_q[k_q]) begin
          state_d = S_Q_UP_CAP;
        end else if (k_q == KTOP) begin
          state_d = S_Q_EQ;
        end else begin
          k_d = k_q + KB'(1);
        end
      end
      S_Q_UP_CAP: begin
        acc_d = smin(acc_q, j_mn);
        a_d = j_anc;
        if (k_q == KTOP) begin
          state_d = S_Q_EQ;
        end else begin
          k_d = k_q + KB'(1); state_d = S_Q_UP;
        end
      end
      S_Q_EQ: begin
        nd_raddr = a_q;
        if (a_q == b_q) begin
          state_d = S_Q_EQ_CAP;
        end else begin
          k_d = KTOP; state_d = S_Q_DN_RA;
        end
      end
      S_Q_EQ_CAP: begin
        acc_d = smin(acc_q, nd_val); state_d = S_RES;
      end
      // lift both ends while their ancestors differ
      S_Q_DN_RA: begin
        jr_addr = {k_q, a_q}; state_d = S_Q_DN_RB;
      end
      S_Q_DN_RB: begin
        x_d = j_anc; m1_d = j_mn;
        jr_addr = {k_q, b_q}; state_d = S_Q_DN_CAP;
      end
      S_Q_DN_CAP: begin
        if (x_q != j_anc) begin
          acc_d = smin(acc_q, smin(m1_q, j_mn));
          a_d = x_q; b_d = j_anc;
        end
        if (k_q == '0) begin
          state_d = S_Q_FA;
        end else begin
          k_d = k_q - KB'(1); state_d = S_Q_DN_RA;
        end
      end
      // both ends and their common parent
      S_Q_FA: begin
        nd_raddr = a_q; jr_addr = {KB'(0), a_q}; state_d = S_Q_FB;
      end
      S_Q_FB: begin
        acc_d = smin(acc_q, nd_val); x_d = j_anc;
        nd_raddr = b_q; state_d = S_Q_FP;
      end
      S_Q_FP: begin
        acc_d = smin(acc_q, nd_val); nd_raddr = x_q; state_d = S_Q_FIN;
      end
      S_Q_FIN: begin
        acc_d = smin(acc_q, nd_val); state_d = S_RES;
      end
      S_RES: begin
        res_o.valid = 1'b1;
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (cfg_wr_i) built_d = 1'b0;
  end

  assign res_min_o = acc_q;

  `TPMQ_ASSERT(a_not_built, clk_i, rst_ni, (in_valid_i && in_ready_o && op_i == OP_QUERY && !built_q) |=> (state_q == S_RES && st_q == ST_NOT_BUILT), "query before build must report not built")
  `TPMQ_ASSERT(a_load_clr, clk_i, rst_ni, (in_valid_i && in_ready_o && op_i == OP_LOAD) |=> !built_q, "load must invalidate tables")
  `TPMQ_ASSERT(a_cfg_clr, clk_i, rst_ni, cfg_wr_i |=> !built_q, "count write must invalidate tables")
  `TPMQ_ASSERT(a_lvl_rng, clk_i, rst_ni, (state_q != S_IDLE) |-> (k_q <= KTOP), "level counter out of range")
  `TPMQ_ASSERT_ALWAYS(a_rst_idle, clk_i, !rst_ni |=> (state_q == S_IDLE && !built_q), "reset must leave sequencer idle")
endmodule

/* rtl/tree_path_min_query_top.sv */
// top level of the tree path minimum block: stream ports, count register, result register
// depends on tpmq_pkg, tpmq_ctrl
// Path minimum over a rooted tree (root node 0) using binary lifting tables held in
// block ram. Load items write one node's value and parent; a build item fills the
// ancestor/minimum tables level by level and then the node depths, one ram read per
// step. A query is taken, reads the two depths, lifts the deeper end level by level by
// the depth difference, compares the ends, lifts both ends together level by level
// while their ancestors differ, reads the final values and hands the result over; the
// joint lift is skipped when the lifted end meets the other. No new item is taken until
// a build or query is through; load items are written while the sequencer stays idle.
// The result sits in an output register, so the next item is taken while it waits.
module tree_path_min_query_top import tpmq_pkg::*; #(
  parameter int MAX_NODES  = 1024,
  parameter int LEVELS     = 10,
  parameter int VALUE_BITS = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // node_id, parent_node, node_value, node_a, node_b
  input  logic [((4*$clog2(MAX_NODES)+VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // op
  input  logic [1:0]                             s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // path_min
  output logic [((VALUE_BITS+7)/8)*8-1:0]        m_axis_tdata,
  // status
  output logic [1:0]                             m_axis_tuser,
  input  logic                                   cfg_we_i,
  input  logic [$clog2(MAX_NODES+1)-1:0]         cfg_wdata_i
);
  localparam int NB = $clog2(MAX_NODES);
  localparam int CB = $clog2(MAX_NODES + 1);
  localparam int VB = VALUE_BITS;
  localparam int OW = ((VB + 7) / 8) * 8;

  logic [CB-1:0] cnt_q;
  res_t res;
  logic signed [VB-1:0] res_min;
  logic res_ready;
  logic out_valid_q;
  logic [VB-1:0] out_min_q;
  status_e out_st_q;

  // node count register, held within 1 .. MAX_NODES
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CB'(1);
    end else if (cfg_we_i) begin
      if (cfg_wdata_i == '0) cnt_q <= CB'(1);
      else if (cfg_wdata_i > CB'(MAX_NODES)) cnt_q <= CB'(MAX_NODES);
      else cnt_q <= cfg_wdata_i;
    end
  end

  tpmq_ctrl #(.MAX_NODES(MAX_NODES), .LEVELS(LEVELS), .VALUE_BITS(VALUE_BITS)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (op_e'(s_axis_tuser)),
    .node_id_i  (s_axis_tdata[NB-1:0]),
    .parent_i   (s_axis_tdata[2*NB-1:NB]),
    .value_i    (s_axis_tdata[2*NB+VB-1:2*NB]),
    .node_a_i   (s_axis_tdata[3*NB+VB-1:2*NB+VB]),
    .node_b_i   (s_axis_tdata[4*NB+VB-1:3*NB+VB]),
    .count_i    (cnt_q),
    .cfg_wr_i   (cfg_we_i),
    .res_o      (res),
    .res_min_o  (res_min),
    .res_ready_i(res_ready)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  // output item register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res.valid) begin
      out_min_q <= res_min;
      out_st_q  <= res.status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OW'(out_min_q);
  assign m_axis_tuser  = out_st_q;
endmodule
